/* rtl/spin_accel_angle_and_magnitude_core_macros.svh */
// Assertion macros for the spin accelerometer angle and magnitude core.
`ifndef SPIN_ACCEL_ANGLE_AND_MAGNITUDE_CORE_MACROS_SVH
`define SPIN_ACCEL_ANGLE_AND_MAGNITUDE_CORE_MACROS_SVH

// Plain property, clocked on i_clk, off during reset.
`define SAAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Overlapped implication, clocked on i_clk, off during reset.
`define SAAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/saam_pkg.sv */
// Package: widths, register indexes and arctangent table for the spin accel core.
`default_nettype none

package saam_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int ALPHA_W          = 16;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int ANGLE_W          = 16;
    localparam int MAG_W            = 16;
    localparam int TURN_W           = 32;
    localparam int FRAC_W           = 8;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    localparam logic [TURN_W-1:0] TURN_ZERO     = 32'h0000_0000;
    localparam logic [TURN_W-1:0] TURN_HALF     = 32'h8000_0000;
    localparam logic [TURN_W-1:0] TURN_QUARTER  = 32'h4000_0000;
    localparam logic [TURN_W-1:0] TURN_NQUARTER = 32'hC000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_ALPHA    = 2'd2,
        CFG_FLOOR    = 2'd3
    } t_cfg_idx;

    // atan(2^-i) in turns, 2^32 per turn
    function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [TURN_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/spin_accel_angle_and_magnitude_core.sv */
// Spin accelerometer core: offset correction, CORDIC atan2 and low-pass |x| magnitude.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: accel_x, accel_y
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: angle_turns, magnitude; tuser: below_floor
//  cfg       in   i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_wdata
//
// One beat in at a time: after an accept the core steps through S_PREP, S_INIT, S_RUN,
// S_FILT and S_OUT before the next accept, paced by the shared step loop that runs one CORDIC
// rotation and one bit of the serial alpha multiply per cycle.
// Result sits in an output register; the core goes back to accepting while it waits.
// A stalled result holds the core in its last state until m_axis_tready.
// Synchronous active-low reset; filter level clears to zero, no clearing pass.
`default_nettype none

module spin_accel_angle_and_magnitude_core
    import saam_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                       i_cfg_index,
    input  logic [CFG_W-1:0]                           i_cfg_wdata,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // accel_x [SAMPLE_WIDTH-1:0], accel_y above it, zero pad
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // angle_turns [15:0], magnitude [31:16]
    output logic [ANGLE_W+MAG_W-1:0]                   m_axis_tdata,
    // below_floor [0]
    output logic                                       m_axis_tuser
);

`include "spin_accel_angle_and_magnitude_core_macros.svh"

    localparam int W         = SAMPLE_WIDTH;
    localparam int DW        = ((W > CFG_W) ? W : CFG_W) + 1;
    localparam int CW        = W + FRAC_W + 2;
    localparam int LW        = W + FRAC_W;
    localparam int TW        = LW + 1;
    localparam int PW        = TW + ALPHA_W;
    localparam int MW        = ((W + 1) > MAG_W) ? (W + 1) : MAG_W;
    localparam int STEPS_MAX = (CORDIC_STEPS > ALPHA_W) ? CORDIC_STEPS : ALPHA_W;
    localparam int CNT_W     = $clog2(STEPS_MAX);

    localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(STEPS_MAX - 1);
    localparam logic [CNT_W:0]   CNT_CORDIC   = (CNT_W+1)'(CORDIC_STEPS);
    localparam logic [CNT_W:0]   CNT_ALPHA    = (CNT_W+1)'(ALPHA_W);
    localparam logic [PW-1:0]    ROUND_ALPHA  = PW'(1) << (ALPHA_W - 1);
    localparam logic [LW:0]      ROUND_FRAC   = (LW+1)'(1) << (FRAC_W - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_INIT = 6'b000100,
        S_RUN  = 6'b001000,
        S_FILT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic signed [CFG_W-1:0] r_off_x, r_off_y;
    logic [ALPHA_W-1:0]     r_alpha;
    logic [CFG_W-1:0]       r_floor;
    logic [LW-1:0]          r_level, n_level;
    logic                   r_out_valid;

    logic signed [W-1:0]    r_raw_x, r_raw_y, r_sx, r_sy;
    logic signed [CW-1:0]   r_cx, r_cy, n_cx, n_cy;
    logic [TURN_W-1:0]      r_cz, n_cz;
    logic                   r_spec, n_spec;
    logic signed [TW-1:0]   r_diff, n_diff;
    logic signed [PW-1:0]   r_acc, n_acc;
    logic [ALPHA_W-1:0]     r_ash, n_ash;
    logic [ANGLE_W-1:0]     r_angle;
    logic [MAG_W-1:0]       r_mag, n_mag;
    logic                   r_low, n_low;

    logic                   w_accept, w_load;
    logic signed [DW-1:0]   w_dx, w_dy;
    logic signed [W-1:0]    w_sat_x, w_sat_y;
    logic signed [CW-1:0]   w_xs, w_ys, w_shx, w_shy;
    logic [W-1:0]           w_abs;
    logic [LW-1:0]          w_target;
    logic                   w_ypos;
    logic [PW-1:0]          w_round;
    logic [LW:0]            w_mag_sum;
    logic [MW-1:0]          w_mag, w_floor;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_mag, r_angle};
    assign m_axis_tuser  = r_low;

    // offset subtraction with saturation to the sample range
    assign w_dx = {{(DW-W){r_raw_x[W-1]}}, r_raw_x} - {{(DW-CFG_W){r_off_x[CFG_W-1]}}, r_off_x};
    assign w_dy = {{(DW-W){r_raw_y[W-1]}}, r_raw_y} - {{(DW-CFG_W){r_off_y[CFG_W-1]}}, r_off_y};

    always_comb begin
        if ((&w_dx[DW-1:W-1]) || !(|w_dx[DW-1:W-1])) begin
            w_sat_x = w_dx[W-1:0];
        end else begin
            w_sat_x = w_dx[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        if ((&w_dy[DW-1:W-1]) || !(|w_dy[DW-1:W-1])) begin
            w_sat_y = w_dy[W-1:0];
        end else begin
            w_sat_y = w_dy[DW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    assign w_xs     = {{(CW-LW){r_sx[W-1]}}, r_sx, {FRAC_W{1'b0}}};
    assign w_ys     = {{(CW-LW){r_sy[W-1]}}, r_sy, {FRAC_W{1'b0}}};
    assign w_abs    = r_sx[W-1] ? W'(-r_sx) : W'(r_sx);
    assign w_target = {w_abs, {FRAC_W{1'b0}}};

    assign w_shx  = r_cx >>> r_cnt;
    assign w_shy  = r_cy >>> r_cnt;
    assign w_ypos = !r_cy[CW-1] && (|r_cy);

    assign w_round   = PW'(r_acc) + ROUND_ALPHA;
    assign w_mag_sum = {1'b0, r_level} + ROUND_FRAC;
    assign w_mag     = MW'(w_mag_sum[LW:FRAC_W]);
    assign w_floor   = MW'(r_floor);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_level = r_level;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_spec  = r_spec;
        n_diff  = r_diff;
        n_acc   = r_acc;
        n_ash   = r_ash;
        n_low   = (w_mag < w_floor);
        n_mag   = n_low ? r_floor : w_mag[MAG_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_INIT;
            end
            S_INIT: begin
                n_state = S_RUN;
                n_cnt   = '0;
                n_acc   = '0;
                n_ash   = r_alpha;
                n_diff  = $signed({1'b0, w_target}) - $signed({1'b0, r_level});
                n_spec  = (r_sx == '0) || (r_sy == '0);
                if (r_sx == '0 && r_sy == '0) begin
                    n_cz = TURN_ZERO;
                end else if (r_sy == '0) begin
                    n_cz = r_sx[W-1] ? TURN_HALF : TURN_ZERO;
                end else if (r_sx == '0) begin
                    n_cz = r_sy[W-1] ? TURN_NQUARTER : TURN_QUARTER;
                end else if (r_sx[W-1]) begin
                    n_cz = TURN_HALF;
                end else begin
                    n_cz = TURN_ZERO;
                end
                n_cx = r_sx[W-1] ? -w_xs : w_xs;
                n_cy = r_sx[W-1] ? -w_ys : w_ys;
            end
            S_RUN: begin
                if (!r_spec && ({1'b0, r_cnt} < CNT_CORDIC)) begin
                    if (w_ypos) begin
                        n_cx = r_cx + w_shy;
                        n_cy = r_cy - w_shx;
                        n_cz = r_cz + atan_turn(ATAN_IDX_W'(r_cnt));
                    end else begin
                        n_cx = r_cx - w_shy;
                        n_cy = r_cy + w_shx;
                        n_cz = r_cz - atan_turn(ATAN_IDX_W'(r_cnt));
                    end
                end
                // alpha multiply, msb first
                if ({1'b0, r_cnt} < CNT_ALPHA) begin
                    n_acc = (r_acc <<< 1) + (r_ash[ALPHA_W-1] ? PW'(r_diff) : PW'(0));
                    n_ash = r_ash << 1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                n_level = r_level + w_round[ALPHA_W +: LW];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_alpha     <= ALPHA_RESET;
            r_floor     <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_level <= n_level;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OFFSET_X: r_off_x <= i_cfg_wdata;
                    CFG_OFFSET_Y: r_off_y <= i_cfg_wdata;
                    CFG_ALPHA:    r_alpha <= i_cfg_wdata;
                    CFG_FLOOR:    r_floor <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw_x <= s_axis_tdata[W-1:0];
            r_raw_y <= s_axis_tdata[2*W-1:W];
        end
        if (r_state == S_PREP) begin
            r_sx <= w_sat_x;
            r_sy <= w_sat_y;
        end
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_spec <= n_spec;
        r_diff <= n_diff;
        r_acc  <= n_acc;
        r_ash  <= n_ash;
        if (w_load) begin
            r_angle <= r_cz[TURN_W-1 -: ANGLE_W] + ANGLE_W'(r_cz[TURN_W-ANGLE_W-1]);
            r_mag   <= n_mag;
            r_low   <= n_low;
        end
    end

    `SAAM_ASSERT(a_accept_to_prep, (s_axis_tvalid && s_axis_tready) |=> (r_state == S_PREP), "accepted beat did not start work")
    `SAAM_ASSERT(a_result_from_out, $rose(m_axis_tvalid) |-> $past(r_state == S_OUT), "result raised outside output state")
    `SAAM_ASSERT(a_run_ends, (r_state == S_RUN && r_cnt == CNT_LAST) |=> (r_state == S_FILT), "step loop overran")
    `SAAM_ASSERT_IMP(a_floor_clamp, m_axis_tvalid && m_axis_tuser, m_axis_tdata[ANGLE_W +: MAG_W] == r_floor, "clamped magnitude differs from floor")

endmodule

`default_nettype wire
